// ===== hw/rtl/cache_tag_lru_controller_core_defines.svh =====
// ----------------------------------------------------------------------------
// Cache tag and LRU controller: assertion macros
// Shared assertion macros for the cache tag and LRU controller.
// ----------------------------------------------------------------------------
`ifndef CACHE_TAG_LRU_CONTROLLER_CORE_DEFINES_SVH
`define CACHE_TAG_LRU_CONTROLLER_CORE_DEFINES_SVH

// Checks that cons holds in the same cycle whenever ante holds.
`define CTLC_CHECK_NOW(name, clk_s, rst_s, ante, cons, msg) \
  name: assert property (@(posedge clk_s) disable iff (rst_s) (ante) |-> (cons)) \
    else $error(msg);

// Checks that cons holds in the cycle after ante holds.
`define CTLC_CHECK_NEXT(name, clk_s, rst_s, ante, cons, msg) \
  name: assert property (@(posedge clk_s) disable iff (rst_s) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== hw/rtl/ctlc_pkg.sv =====
// ----------------------------------------------------------------------------
// ctlc_pkg
// Sizes, types and state codes shared by the cache tag controller modules.
// ----------------------------------------------------------------------------
package ctlc_pkg;

  localparam int LINES  = 16;
  localparam int IDX_W  = $clog2(LINES);
  localparam int RANK_W = IDX_W;
  localparam int ADDR_W = 16;
  localparam int LINE_W = 4;

  // Reciprocal used to take the address modulo the line count.
  localparam int DM_SHIFT = ADDR_W + IDX_W;
  localparam int PROD_W   = ADDR_W + DM_SHIFT;
  localparam longint DM_RECIP = (64'(1) << DM_SHIFT) / LINES;

  localparam logic [RANK_W-1:0] RANK_MAX = RANK_W'(LINES - 1);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_LOOK,
    ST_SCAN,
    ST_UPDATE
  } state_t;

  typedef struct packed {
    logic              valid;
    logic [ADDR_W-1:0] tag;
    logic [RANK_W-1:0] rank;
  } cell_state_t;

  typedef struct packed {
    logic              have;
    logic [RANK_W-1:0] rank;
    logic [IDX_W-1:0]  idx;
  } scan_t;

  typedef struct packed {
    logic              en;
    logic [IDX_W-1:0]  idx;
    logic [RANK_W-1:0] mine;
    logic              touch;
    logic              clear_rank;
    logic              fill;
    logic [ADDR_W-1:0] tag;
  } upd_cmd_t;

endpackage

// ===== hw/rtl/cache_tag_lru_controller_core.sv =====
// ----------------------------------------------------------------------------
// cache_tag_lru_controller_core
// Tag lookup and replacement engine of a write-through, write-allocate
// word cache, built as a row of line cells.
// ----------------------------------------------------------------------------
//
//  Channel   Handshake             Payload
//  -------   -------------------   -----------------------------------------
//  request   in_valid / in_ready   op, address
//  result    out_valid / out_ready hit, line, memory_read, memory_write,
//                                  evicted_valid, evicted_address
//  config    cfg_valid / cfg_ready cfg_data (mapping mode)
//
// A request goes from lookup straight to update when it hits, when an
// empty line can be filled, or in direct-mapped mode. An associative miss
// with every line valid waits in the scan state in between, since the oldest
// line is found by a search wave that moves one cell per cycle.
// A new request is accepted in the update cycle of the previous one, while
// a finished result may still sit in the output register.
// Reset is synchronous and empties all lines; a full output register holds
// the update cycle until the result is taken.
// ----------------------------------------------------------------------------
`include "cache_tag_lru_controller_core_defines.svh"

module cache_tag_lru_controller_core (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic                          op,
  input  logic [ctlc_pkg::ADDR_W-1:0]   address,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic                          hit,
  output logic [ctlc_pkg::LINE_W-1:0]   line,
  output logic                          memory_read,
  output logic                          memory_write,
  output logic                          evicted_valid,
  output logic [ctlc_pkg::ADDR_W-1:0]   evicted_address,
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic                          cfg_data
);

  // Index of the lowest set bit. The lowest bit is isolated with a single
  // add, then encoded by OR-ing the indices of independent bits.
  function automatic logic [ctlc_pkg::IDX_W-1:0] lowest_index(
    input logic [ctlc_pkg::LINES-1:0] v
  );
    logic [ctlc_pkg::LINES-1:0] iso;
    logic [ctlc_pkg::IDX_W-1:0] r;
    iso = v & (~v + ctlc_pkg::LINES'(1));
    r   = '0;
    for (int k = 0; k < ctlc_pkg::LINES; k++) begin
      if (iso[k]) begin
        r = r | ctlc_pkg::IDX_W'(k);
      end
    end
    return r;
  endfunction

  ctlc_pkg::state_t               state, state_next;
  logic                           mapping_mode;

  // Request registers, loaded when a request is accepted.
  logic                           req_op;
  logic [ctlc_pkg::ADDR_W-1:0]    req_addr;
  logic [ctlc_pkg::ADDR_W-1:0]    req_qhat;
  logic [ctlc_pkg::PROD_W-1:0]    qprod;

  // Decision registers handed from lookup or scan to the update cycle.
  logic [ctlc_pkg::IDX_W-1:0]     upd_idx, upd_idx_next;
  logic                           upd_hit, upd_hit_next;
  logic [ctlc_pkg::IDX_W-1:0]     scan_cnt, scan_cnt_next;

  logic                           accept;
  logic                           upd_fire;

  ctlc_pkg::cell_state_t          cell_st [ctlc_pkg::LINES];
  ctlc_pkg::scan_t                scan_link [ctlc_pkg::LINES+1];
  logic [ctlc_pkg::LINES-1:0]     valid_vec;
  logic [ctlc_pkg::LINES-1:0]     match_vec;
  ctlc_pkg::upd_cmd_t             cmd;
  ctlc_pkg::cell_state_t          sel_state;

  // Direct-mapped line: address minus an estimated quotient times LINES.
  // The estimate is low by at most one, so one correction step suffices.
  logic [ctlc_pkg::IDX_W:0]       dm_rem;
  logic [ctlc_pkg::IDX_W-1:0]     dm_idx;

  assign cfg_ready = 1'b1;
  assign accept    = in_valid && in_ready;

  assign qprod = ctlc_pkg::PROD_W'(address) * ctlc_pkg::PROD_W'(ctlc_pkg::DM_RECIP);

  assign dm_rem = (ctlc_pkg::IDX_W+1)'(req_addr -
                  ctlc_pkg::ADDR_W'(req_qhat * ctlc_pkg::LINES));
  assign dm_idx = (dm_rem >= (ctlc_pkg::IDX_W+1)'(ctlc_pkg::LINES)) ?
                  ctlc_pkg::IDX_W'(dm_rem - (ctlc_pkg::IDX_W+1)'(ctlc_pkg::LINES)) :
                  ctlc_pkg::IDX_W'(dm_rem);

  // The search wave enters the first cell with no candidate.
  assign scan_link[0] = '0;

  for (genvar g = 0; g < ctlc_pkg::LINES; g++) begin : g_cell
    ctlc_cell u_cell (
      .clk         (clk),
      .rst         (rst),
      .cell_index  (ctlc_pkg::IDX_W'(g)),
      .lookup_addr (req_addr),
      .cmd         (cmd),
      .scan_in     (scan_link[g]),
      .scan_out    (scan_link[g+1]),
      .status      (cell_st[g]),
      .match_hit   (match_vec[g])
    );
    assign valid_vec[g] = cell_st[g].valid;
  end

  assign sel_state = cell_st[upd_idx];

  // In associative mode the touched line is aged to the top rank and lines
  // above its old rank move down; in direct-mapped mode a write clears the
  // rank of its line. A miss always fills the chosen line.
  always_comb begin
    cmd.en         = upd_fire;
    cmd.idx        = upd_idx;
    cmd.mine       = sel_state.rank;
    cmd.touch      = !mapping_mode;
    cmd.clear_rank = mapping_mode && req_op;
    cmd.fill       = !upd_hit;
    cmd.tag        = req_addr;
  end

  // Controller: lookup decides the line unless every line is valid on an
  // associative miss, in which case the search wave is awaited.
  always_comb begin
    state_next    = state;
    upd_idx_next  = upd_idx;
    upd_hit_next  = upd_hit;
    scan_cnt_next = scan_cnt;
    upd_fire      = 1'b0;
    in_ready      = 1'b0;
    case (state)
      ctlc_pkg::ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          state_next = ctlc_pkg::ST_LOOK;
        end
      end
      ctlc_pkg::ST_LOOK: begin
        if (mapping_mode) begin
          upd_idx_next = dm_idx;
          upd_hit_next = match_vec[dm_idx];
          state_next   = ctlc_pkg::ST_UPDATE;
        end else if (|match_vec) begin
          upd_idx_next = lowest_index(match_vec);
          upd_hit_next = 1'b1;
          state_next   = ctlc_pkg::ST_UPDATE;
        end else if (!(&valid_vec)) begin
          upd_idx_next = lowest_index(~valid_vec);
          upd_hit_next = 1'b0;
          state_next   = ctlc_pkg::ST_UPDATE;
        end else begin
          upd_hit_next  = 1'b0;
          scan_cnt_next = ctlc_pkg::IDX_W'(ctlc_pkg::LINES - 1);
          state_next    = ctlc_pkg::ST_SCAN;
        end
      end
      ctlc_pkg::ST_SCAN: begin
        if (scan_cnt == '0) begin
          upd_idx_next = scan_link[ctlc_pkg::LINES].idx;
          state_next   = ctlc_pkg::ST_UPDATE;
        end else begin
          scan_cnt_next = scan_cnt - 1'b1;
        end
      end
      ctlc_pkg::ST_UPDATE: begin
        upd_fire = !out_valid || out_ready;
        in_ready = upd_fire;
        if (upd_fire) begin
          state_next = in_valid ? ctlc_pkg::ST_LOOK : ctlc_pkg::ST_IDLE;
        end
      end
      default: begin
        state_next = ctlc_pkg::ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= ctlc_pkg::ST_IDLE;
      mapping_mode <= 1'b0;
      out_valid    <= 1'b0;
    end else begin
      state <= state_next;
      if (cfg_valid && cfg_ready) begin
        mapping_mode <= cfg_data;
      end
      if (upd_fire) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    upd_idx  <= upd_idx_next;
    upd_hit  <= upd_hit_next;
    scan_cnt <= scan_cnt_next;
    if (accept) begin
      req_op   <= op;
      req_addr <= address;
      req_qhat <= qprod[ctlc_pkg::PROD_W-1:ctlc_pkg::DM_SHIFT];
    end
  end

  // Result register. An eviction is a miss on a line that was valid.
  always_ff @(posedge clk) begin
    if (upd_fire) begin
      hit             <= upd_hit;
      line            <= ctlc_pkg::LINE_W'(upd_idx);
      memory_read     <= !upd_hit && !req_op;
      memory_write    <= req_op;
      evicted_valid   <= !upd_hit && sel_state.valid;
      evicted_address <= (!upd_hit && sel_state.valid) ? sel_state.tag : '0;
    end
  end

  `CTLC_CHECK_NOW(a_hit_no_refill, clk, rst, out_valid && hit, !memory_read && !evicted_valid, "hit result reports a refill or an eviction")
  `CTLC_CHECK_NOW(a_scan_only_when_full, clk, rst, state == ctlc_pkg::ST_SCAN, &valid_vec, "replacement search started with an empty line available")
  `CTLC_CHECK_NEXT(a_accept_to_lookup, clk, rst, accept, state == ctlc_pkg::ST_LOOK, "accepted request did not enter lookup")
  `CTLC_CHECK_NEXT(a_touch_top_rank, clk, rst, upd_fire && !mapping_mode, sel_state.rank == ctlc_pkg::RANK_MAX, "touched line did not reach the top rank")

endmodule

// ===== hw/rtl/ctlc_cell.sv =====
// ----------------------------------------------------------------------------
// ctlc_cell
// One cache line: tag, valid bit and usage rank, with a stage of the
// least-recently-used search chain.
// ----------------------------------------------------------------------------
module ctlc_cell (
  input  logic                         clk,
  input  logic                         rst,
  input  logic [ctlc_pkg::IDX_W-1:0]   cell_index,
  input  logic [ctlc_pkg::ADDR_W-1:0]  lookup_addr,
  input  ctlc_pkg::upd_cmd_t           cmd,
  input  ctlc_pkg::scan_t              scan_in,
  output ctlc_pkg::scan_t              scan_out,
  output ctlc_pkg::cell_state_t        status,
  output logic                         match_hit
);

  logic                          valid;
  logic [ctlc_pkg::ADDR_W-1:0]   tag;
  logic [ctlc_pkg::RANK_W-1:0]   rank;
  logic                          sel;
  ctlc_pkg::scan_t               scan_next;

  assign sel       = (cmd.idx == cell_index);
  assign match_hit = valid && (tag == lookup_addr);
  assign status    = '{valid: valid, tag: tag, rank: rank};

  // A valid line with a smaller rank than everything to its left wins;
  // equal ranks keep the lower index.
  always_comb begin
    scan_next = scan_in;
    if (valid && (!scan_in.have || rank < scan_in.rank)) begin
      scan_next = '{have: 1'b1, rank: rank, idx: cell_index};
    end
  end

  always_ff @(posedge clk) begin
    scan_out <= scan_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
      rank  <= '0;
    end else if (cmd.en) begin
      if (cmd.touch) begin
        if (sel) begin
          rank <= ctlc_pkg::RANK_MAX;
        end else if (valid && rank > cmd.mine) begin
          rank <= rank - 1'b1;
        end
      end else if (cmd.clear_rank && sel) begin
        rank <= '0;
      end
      if (cmd.fill && sel) begin
        valid <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.en && cmd.fill && sel) begin
      tag <= cmd.tag;
    end
  end

endmodule

// ===== sim/cache_tag_lru_controller_core_test.sv =====
// ----------------------------------------------------------------------------
// cache_tag_lru_controller_core_test
// Self-checking bench for the cache tag and LRU engine. A scoreboard object
// keeps its own copy of the line tags, valid bits and usage ranks, predicts
// the outcome of every accepted request, and compares it with each result
// the block hands out, in both associative and direct-mapped mode.
// ----------------------------------------------------------------------------
module cache_tag_lru_controller_core_test;
  timeunit 1ns;
  timeprecision 1ps;

  // Access kinds and mapping modes, as carried on op and cfg_data.
  localparam logic OP_READ     = 1'b0;
  localparam logic OP_WRITE    = 1'b1;
  localparam logic MODE_ASSOC  = 1'b0;
  localparam logic MODE_DIRECT = 1'b1;

  // The slowest request waits out the whole search wave, and the receiver may
  // stall at random on each result; this bound is far above that.
  localparam int unsigned CYCLE_LIMIT  = 400000;
  localparam int          ITEMS_PER_SEG = 100;
  localparam int          MAX_GAP       = 40;
  localparam int          MAX_PRINTS    = 40;

  typedef struct packed {
    logic                        hit;
    logic [ctlc_pkg::LINE_W-1:0] line;
    logic                        memory_read;
    logic                        memory_write;
    logic                        evicted_valid;
    logic [ctlc_pkg::ADDR_W-1:0] evicted_address;
  } access_result_t;

  // --------------------------------------------------------------------------
  // Scoreboard: a private copy of the tag store and the queue of outcomes
  // that accepted requests are owed.
  // --------------------------------------------------------------------------
  class access_scoreboard;
    logic [ctlc_pkg::ADDR_W-1:0] tag_store [ctlc_pkg::LINES];
    logic                        valid_store [ctlc_pkg::LINES];
    logic [ctlc_pkg::RANK_W-1:0] rank_store [ctlc_pkg::LINES];
    logic              mapping_mode;
    access_result_t    owed_q [$];
    int unsigned       errors;
    int unsigned       requests;
    int unsigned       hits;
    int unsigned       evictions;
    int unsigned       writes;
    int unsigned       mode_writes;

    function new();
      for (int k = 0; k < ctlc_pkg::LINES; k++) begin
        tag_store[k]   = '0;
        valid_store[k] = 1'b0;
        rank_store[k]  = '0;
      end
      mapping_mode = MODE_ASSOC;
      errors       = 0;
      requests     = 0;
      hits         = 0;
      evictions    = 0;
      writes       = 0;
      mode_writes  = 0;
    endfunction

    function void set_mode(logic m);
      mapping_mode = m;
      mode_writes++;
    endfunction

    function int pending();
      return owed_q.size();
    endfunction

    // Works out the outcome of one accepted request and updates the store.
    function void note_access(logic is_write, logic [ctlc_pkg::ADDR_W-1:0] addr);
      int             idx;
      int             empty_idx;
      int             lru_idx;
      bit             found;
      bit             have_empty;
      bit             have_lru;
      logic [ctlc_pkg::RANK_W-1:0] mine;
      access_result_t res;

      idx        = 0;
      empty_idx  = 0;
      lru_idx    = 0;
      found      = 1'b0;
      have_empty = 1'b0;
      have_lru   = 1'b0;

      if (mapping_mode == MODE_ASSOC) begin
        for (int k = 0; k < ctlc_pkg::LINES; k++) begin
          if (!found && valid_store[k] && tag_store[k] == addr) begin
            found = 1'b1;
            idx   = k;
          end
        end
        if (!found) begin
          // First empty line wins; with none empty, the lowest rank, and the
          // lowest index among equal ranks.
          for (int k = 0; k < ctlc_pkg::LINES; k++) begin
            if (!valid_store[k]) begin
              if (!have_empty) begin
                have_empty = 1'b1;
                empty_idx  = k;
              end
            end else if (!have_lru || rank_store[k] < rank_store[lru_idx]) begin
              lru_idx  = k;
              have_lru = 1'b1;
            end
          end
          idx = have_empty ? empty_idx : lru_idx;
        end
      end else begin
        idx   = int'(addr) % ctlc_pkg::LINES;
        found = valid_store[idx] && tag_store[idx] == addr;
      end

      res.hit             = found;
      res.line            = ctlc_pkg::LINE_W'(idx);
      res.memory_read     = !found && is_write == OP_READ;
      res.memory_write    = is_write == OP_WRITE;
      res.evicted_valid   = !found && valid_store[idx];
      res.evicted_address = res.evicted_valid ? tag_store[idx] : '0;

      if (mapping_mode == MODE_ASSOC) begin
        mine = rank_store[idx];
        for (int k = 0; k < ctlc_pkg::LINES; k++) begin
          if (valid_store[k] && rank_store[k] > mine)
            rank_store[k] = rank_store[k] - 1'b1;
        end
        rank_store[idx] = ctlc_pkg::RANK_W'(ctlc_pkg::LINES - 1);
      end else if (is_write == OP_WRITE) begin
        rank_store[idx] = '0;
      end

      if (!found) begin
        valid_store[idx] = 1'b1;
        tag_store[idx]   = addr;
      end

      requests++;
      if (found) hits++;
      if (res.evicted_valid) evictions++;
      if (is_write == OP_WRITE) writes++;
      owed_q.push_back(res);
    endfunction

    task report_mismatch(string what, int unsigned got, int unsigned want);
      errors++;
      if (errors <= MAX_PRINTS)
        $display("MISMATCH after %0d requests: %s got 0x%0h, expected 0x%0h",
                 requests, what, got, want);
    endtask

    task check_result(access_result_t got);
      access_result_t want;
      if (owed_q.size() == 0) begin
        report_mismatch("result with no request outstanding", 32'(got.line), 0);
        return;
      end
      want = owed_q.pop_front();
      if (got.hit !== want.hit)
        report_mismatch("hit", 32'(got.hit), 32'(want.hit));
      if (got.line !== want.line)
        report_mismatch("line", 32'(got.line), 32'(want.line));
      if (got.memory_read !== want.memory_read)
        report_mismatch("memory_read", 32'(got.memory_read), 32'(want.memory_read));
      if (got.memory_write !== want.memory_write)
        report_mismatch("memory_write", 32'(got.memory_write), 32'(want.memory_write));
      if (got.evicted_valid !== want.evicted_valid)
        report_mismatch("evicted_valid", 32'(got.evicted_valid),
                        32'(want.evicted_valid));
      if (got.evicted_address !== want.evicted_address)
        report_mismatch("evicted_address", 32'(got.evicted_address),
                        32'(want.evicted_address));
    endtask
  endclass

  // --------------------------------------------------------------------------
  // Clock, reset and the signals around the block. Every input starts at a
  // known value; reset is held high from time zero.
  // --------------------------------------------------------------------------
  logic                        clk = 1'b0;
  logic                        rst = 1'b1;
  logic                        req_valid = 1'b0;
  logic                        req_ready;
  logic                        req_op = OP_READ;
  logic [ctlc_pkg::ADDR_W-1:0] req_address = '0;
  logic                        rsp_valid;
  logic                        rsp_ready = 1'b0;
  logic                        rsp_hit;
  logic [ctlc_pkg::LINE_W-1:0] rsp_line;
  logic                        rsp_memory_read;
  logic                        rsp_memory_write;
  logic                        rsp_evicted_valid;
  logic [ctlc_pkg::ADDR_W-1:0] rsp_evicted_address;
  logic                        cfg_valid = 1'b0;
  logic                        cfg_ready;
  logic                        cfg_data = MODE_ASSOC;

  // Idle percentages for the request sender and the result receiver.
  int unsigned send_idle_pct = 0;
  int unsigned recv_idle_pct = 0;
  int unsigned cycle_count   = 0;

  // Working set of addresses for the random part, so that lines get hit,
  // aged and replaced instead of every request missing.
  logic [ctlc_pkg::ADDR_W-1:0] addr_pool [32];
  int                          pool_size = 1;

  access_scoreboard sb = new();

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  cache_tag_lru_controller_core u_top (
    .clk             (clk),
    .rst             (rst),
    .in_valid        (req_valid),
    .in_ready        (req_ready),
    .op              (req_op),
    .address         (req_address),
    .out_valid       (rsp_valid),
    .out_ready       (rsp_ready),
    .hit             (rsp_hit),
    .line            (rsp_line),
    .memory_read     (rsp_memory_read),
    .memory_write    (rsp_memory_write),
    .evicted_valid   (rsp_evicted_valid),
    .evicted_address (rsp_evicted_address),
    .cfg_valid       (cfg_valid),
    .cfg_ready       (cfg_ready),
    .cfg_data        (cfg_data)
  );

  // The receiver stalls at random, decided afresh at every edge.
  always @(posedge clk) begin
    rsp_ready <= ($urandom_range(0, 99) >= recv_idle_pct);
  end

  // Monitor: values are read at the edge, before any update of that edge
  // lands, so both handshakes are seen exactly as the block saw them. A
  // result never shows up at the edge that accepts its request, so the order
  // of the two checks below does not matter.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (!rst) begin
      if (rsp_valid && rsp_ready)
        sb.check_result('{rsp_hit, rsp_line, rsp_memory_read, rsp_memory_write,
                          rsp_evicted_valid, rsp_evicted_address});
      if (req_valid && req_ready)
        sb.note_access(req_op, req_address);
    end
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("timeout: run stopped after %0d cycles", cycle_count);
      $display("simulation failed");
      $finish;
    end
  end

  // --------------------------------------------------------------------------
  // Request driver. Valid is only lowered when a gap follows, so a request
  // that comes right after the previous one keeps valid high without a drop
  // in the same time step.
  // --------------------------------------------------------------------------
  task automatic send_access(input logic is_write,
                             input logic [ctlc_pkg::ADDR_W-1:0] addr);
    int gap;
    gap = 0;
    while (gap < MAX_GAP && $urandom_range(0, 99) < send_idle_pct)
      gap++;
    if (gap > 0) begin
      req_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    req_valid   <= 1'b1;
    req_op      <= is_write;
    req_address <= addr;
    do @(posedge clk); while (!(req_valid && req_ready));
  endtask

  // The mode register is only written with no request in flight. Valid is
  // dropped first, so that the monitor notes every accepted request, and every
  // owed result must have come back before the write is offered.
  task automatic write_mode(input logic m);
    req_valid <= 1'b0;
    @(posedge clk);
    while (sb.pending() != 0) @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_data  <= m;
    do @(posedge clk); while (!(cfg_valid && cfg_ready));
    cfg_valid <= 1'b0;
    sb.set_mode(m);
  endtask

  // A fresh working set; its size decides whether the associative mode
  // mostly hits or keeps replacing lines.
  task automatic refresh_pool();
    pool_size = $urandom_range(10, 24);
    for (int k = 0; k < 32; k++)
      addr_pool[k] = ctlc_pkg::ADDR_W'($urandom);
  endtask

  // Mostly working-set addresses, some that collide with them on the low
  // bits (direct-mapped conflicts), and some drawn from the whole range.
  function automatic logic [ctlc_pkg::ADDR_W-1:0] pick_address();
    int                          r;
    logic [ctlc_pkg::ADDR_W-1:0] base;
    r    = $urandom_range(0, 99);
    base = addr_pool[$urandom_range(0, pool_size - 1)];
    if (r < 70)
      return base;
    else if (r < 85)
      return {12'($urandom_range(0, 4095)), base[3:0]};
    else
      return ctlc_pkg::ADDR_W'($urandom);
  endfunction

  // --------------------------------------------------------------------------
  // Stimulus.
  // --------------------------------------------------------------------------
  initial begin
    rst = 1'b1;
    repeat (7) @(posedge clk);
    rst <= 1'b0;

    // Directed part, under the first idle pattern.
    send_idle_pct = 19;
    recv_idle_pct = 84;
    write_mode(MODE_ASSOC);

    // Tag zero in an empty line must miss, then hit.
    send_access(OP_READ, 16'h0000);
    send_access(OP_READ, 16'h0000);
    // A write miss allocates without a memory read; then a write hit.
    send_access(OP_WRITE, 16'hFFFF);
    send_access(OP_WRITE, 16'hFFFF);
    // Fill every remaining line, then miss with the set full so the least
    // recently used line is replaced, once by a read and once by a write.
    for (int k = 1; k <= 14; k++)
      send_access(OP_READ, 16'(k * 16));
    send_access(OP_READ, 16'h8000);
    send_access(OP_WRITE, 16'h5555);

    // Switching mode keeps the lines; lookups now go by the low bits.
    write_mode(MODE_DIRECT);
    send_access(OP_READ, 16'h0000);
    send_access(OP_WRITE, 16'h0010);
    send_access(OP_READ, 16'hFFFF);
    send_access(OP_READ, 16'h1230);
    send_access(OP_WRITE, 16'hABCF);

    // Random part: three idle patterns, each run in both mapping modes.
    for (int phase = 0; phase < 3; phase++) begin
      case (phase)
        0: begin
          send_idle_pct = 19;
          recv_idle_pct = 84;
        end
        1: begin
          send_idle_pct = 84;
          recv_idle_pct = 19;
        end
        default: begin
          send_idle_pct = 0;
          recv_idle_pct = 0;
        end
      endcase
      for (int seg = 0; seg < 2; seg++) begin
        write_mode(seg == 0 ? MODE_ASSOC : MODE_DIRECT);
        refresh_pool();
        repeat (ITEMS_PER_SEG)
          send_access(1'($urandom_range(0, 1)), pick_address());
      end
    end

    // Drain, then give the block time to show any stray result.
    req_valid <= 1'b0;
    @(posedge clk);
    while (sb.pending() != 0) @(posedge clk);
    repeat (ctlc_pkg::LINES + 4) @(posedge clk);

    $display("Ran %0d requests with %0d hits, %0d evictions and %0d writes,",
             sb.requests, sb.hits, sb.evictions, sb.writes);
    $display("over %0d mode register writes; %0d mismatches.",
             sb.mode_writes, sb.errors);
    if (sb.errors == 0)
      $display("simulation ok");
    else
      $display("simulation failed");
    $finish;
  end

endmodule

// ===== filelist.f =====
+incdir+hw/rtl
hw/rtl/ctlc_pkg.sv
hw/rtl/ctlc_cell.sv
hw/rtl/cache_tag_lru_controller_core.sv
sim/cache_tag_lru_controller_core_test.sv
